// ===== rtl/core/upe_pkg.sv =====
`default_nettype none

package upe_pkg;

  // most characters that one byte can release: a broken escape flush plus an encoded byte
  localparam int MaxChars = 5;
  localparam int CntW     = $clog2(MaxChars + 1);

  localparam logic [1:0] SetPath     = 2'd0;
  localparam logic [1:0] SetQuery    = 2'd1;
  localparam logic [1:0] SetFragment = 2'd2;

  localparam logic [7:0] Percent = 8'h25;

  typedef logic [6:0]      char_t;
  typedef logic [CntW-1:0] cnt_t;

  // characters released by one request, in output order from index 0
  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    cnt_t                 cnt;
  } bundle_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic char_t to_upper_hex(input logic [7:0] b);
    if (b inside {[8'h61:8'h66]}) begin
      return char_t'(b - 8'h20);
    end
    return b[6:0];
  endfunction

  function automatic char_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return char_t'({3'b011, nib});
    end
    return char_t'(8'h37 + {4'd0, nib});
  endfunction

  // keep-set membership; selector value 3 acts as the fragment set
  function automatic logic is_kept(input logic [7:0] b, input logic [1:0] sel);
    logic common;
    logic extra;
    common = (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                        8'h2D, 8'h2E, 8'h5F, 8'h7E,
                        8'h21, 8'h24, 8'h25, 8'h26, [8'h28:8'h2C], 8'h2F,
                        8'h3A, 8'h3B, 8'h3D, 8'h40, [8'h5B:8'h5E], 8'h7C});
    case (sel)
      SetPath:  extra = (b == 8'h27);
      SetQuery: extra = (b inside {8'h3F, 8'h60, 8'h7B, 8'h7D});
      default:  extra = (b inside {8'h23, 8'h27, 8'h3F, 8'h7B, 8'h7D});
    endcase
    return common || extra;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/upe_in_if.sv =====
`default_nettype none

interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/upe_out_if.sv =====
`default_nettype none

interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/upe_cfg_if.sv =====
`default_nettype none

interface upe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/upe_step.sv =====
`default_nettype none

module upe_step (
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  input  wire logic [1:0]      keep_set,
  input  wire logic [1:0]      la_count,
  input  wire logic [7:0]      la_digit,
  output upe_pkg::bundle_t     bundle,
  output logic      [1:0]      la_count_next,
  output logic      [7:0]      la_digit_next
);

  upe_pkg::char_t [1:0] pre;
  logic [1:0]           pre_cnt;
  upe_pkg::char_t [2:0] tail;
  logic [1:0]           tail_cnt;
  logic                 tail_on;
  logic                 hold_pct;
  logic                 byte_hex;

  always_comb begin
    byte_hex = upe_pkg::is_hex(in_byte);

    // the new byte processed on its own
    tail_cnt = 2'd0;
    tail     = '0;
    hold_pct = (in_byte == upe_pkg::Percent) && !in_last;
    if (!hold_pct) begin
      if (!in_byte[7] && upe_pkg::is_kept(in_byte, keep_set)) begin
        tail[0]  = in_byte[6:0];
        tail_cnt = 2'd1;
      end else begin
        tail[0]  = upe_pkg::char_t'(upe_pkg::Percent);
        tail[1]  = upe_pkg::hex_char(in_byte[7:4]);
        tail[2]  = upe_pkg::hex_char(in_byte[3:0]);
        tail_cnt = 2'd3;
      end
    end

    pre           = '0;
    pre_cnt       = 2'd0;
    tail_on       = 1'b1;
    la_count_next = hold_pct ? 2'd1 : 2'd0;
    la_digit_next = la_digit;

    case (la_count)
      2'd0: begin
      end
      2'd1: begin
        pre[0]  = upe_pkg::char_t'(upe_pkg::Percent);
        pre_cnt = 2'd1;
        if (byte_hex) begin
          tail_on = 1'b0;
          if (in_last) begin
            // lone escape start at the end: literal percent and the digit
            pre[1]        = in_byte[6:0];
            pre_cnt       = 2'd2;
            la_count_next = 2'd0;
          end else begin
            pre_cnt       = 2'd0;
            la_count_next = 2'd2;
            la_digit_next = in_byte;
          end
        end
      end
      default: begin
        pre[0]  = upe_pkg::char_t'(upe_pkg::Percent);
        pre_cnt = 2'd2;
        if (byte_hex) begin
          // complete escape, digits normalized to upper case
          tail_on       = 1'b0;
          pre[1]        = upe_pkg::to_upper_hex(la_digit);
          tail[0]       = upe_pkg::to_upper_hex(in_byte);
          la_count_next = 2'd0;
        end else begin
          pre[1] = la_digit[6:0];
        end
      end
    endcase

    if (!tail_on) begin
      // only the completed escape adds its last digit
      tail_cnt = (la_count >= 2'd2) ? 2'd1 : 2'd0;
    end

    bundle.chars = '0;
    case (pre_cnt)
      2'd0: begin
        bundle.chars[0] = tail[0];
        bundle.chars[1] = tail[1];
        bundle.chars[2] = tail[2];
      end
      2'd1: begin
        bundle.chars[0] = pre[0];
        bundle.chars[1] = tail[0];
        bundle.chars[2] = tail[1];
        bundle.chars[3] = tail[2];
      end
      default: begin
        bundle.chars[0] = pre[0];
        bundle.chars[1] = pre[1];
        bundle.chars[2] = tail[0];
        bundle.chars[3] = tail[1];
        bundle.chars[4] = tail[2];
      end
    endcase
    bundle.cnt = upe_pkg::cnt_t'(pre_cnt) + upe_pkg::cnt_t'(tail_cnt);
  end

endmodule

`default_nettype wire

// ===== rtl/core/url_percent_encoder.sv =====
// url_percent_encoder: streaming percent-encoder for one URL component
//
// in_ch carries the UTF-8 bytes of the component, in_last on its final byte.
// out_ch carries one ASCII character per request, out_last on the final one.
// cfg writes keep_set (0 path, 1 query, 2 fragment); write it only while idle.
// cfg is always ready.
//
// out_ch is driven straight from the result register, so the characters that a
// taken byte releases are registered. A '%' and the hex digit after it are held
// back until the next byte tells whether they form an escape; they never
// show on their own until then.
// throughput: the output side moves one character per cycle while the receiver
// is ready. A kept byte releases one character, an encoded byte or a completed
// escape three, and a broken escape flushed ahead of an encoded byte up to five.
// Bytes that release nothing are taken without loading the result register.
// A new byte is taken in the cycle the last buffered character leaves.
// reset: lookahead empty, output register empty, keep_set = path.
// when the receiver stalls, the current character holds and in_ch backs up.
`default_nettype none

module url_percent_encoder (
  input wire logic  clk,
  input wire logic  rst,
  upe_in_if.sink    in_ch,
  upe_out_if.source out_ch,
  upe_cfg_if.sink   cfg
);

  // configuration register
  logic [1:0] keep_set;

  // lookahead: count of held bytes; the first is always '%', the second a hex digit
  logic [1:0] la_count;
  logic [1:0] la_count_next;
  logic [7:0] la_digit;
  logic [7:0] la_digit_next;

  // result register: characters still to send for the current request
  upe_pkg::char_t [upe_pkg::MaxChars-1:0] chars;
  upe_pkg::cnt_t                          cnt;
  logic                                   last;

  upe_pkg::bundle_t step;
  logic             in_take;
  logic             out_take;

  upe_step u_step (
    .in_byte       (in_ch.in_byte),
    .in_last       (in_ch.in_last),
    .keep_set      (keep_set),
    .la_count      (la_count),
    .la_digit      (la_digit),
    .bundle        (step),
    .la_count_next (la_count_next),
    .la_digit_next (la_digit_next)
  );

  assign cfg.ready = 1'b1;

  // output straight from the result register, head character first
  assign out_ch.valid    = (cnt != '0);
  assign out_ch.out_char = chars[0];
  assign out_ch.out_last = last && (cnt == upe_pkg::cnt_t'(1));
  assign out_take        = out_ch.valid && out_ch.ready;

  // free, or the last waiting character leaves in this cycle
  assign in_ch.ready = (cnt == '0) || ((cnt == upe_pkg::cnt_t'(1)) && out_ch.ready);
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_set <= upe_pkg::SetPath;
      la_count <= 2'd0;
      cnt      <= '0;
    end else begin
      if (cfg.valid) begin
        keep_set <= cfg.data;
      end
      if (in_take) begin
        la_count <= la_count_next;
        la_digit <= la_digit_next;
      end
      if (in_take && (step.cnt != '0)) begin
        chars <= step.chars;
        cnt   <= step.cnt;
        last  <= in_ch.in_last;
      end else if (out_take) begin
        // shift the next character to the head
        chars <= {upe_pkg::char_t'(0), chars[upe_pkg::MaxChars-1:1]};
        cnt   <= cnt - upe_pkg::cnt_t'(1);
      end
    end
  end

  // the last byte always empties the lookahead
  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    in_take && in_ch.in_last |=> la_count == 2'd0)
    else $error("lookahead not empty after last byte");

  // the last byte always releases at least one character
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    in_take && in_ch.in_last |=> cnt != '0)
    else $error("last byte released no character");

  // never more than two bytes held
  a_la_bound: assert property (@(posedge clk) disable iff (rst)
    la_count != 2'd3)
    else $error("lookahead count out of range");

  // result register never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= upe_pkg::cnt_t'(upe_pkg::MaxChars))
    else $error("result count out of range");

endmodule

`default_nettype wire
